@@ design/typed_slot_dispatcher_assert.svh @@
// Assertion macros shared by the dispatcher's checker.
`ifndef TYPED_SLOT_DISPATCHER_ASSERT_SVH
`define TYPED_SLOT_DISPATCHER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked out of reset.
`define TSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ design/tsd_pkg.sv @@
// Types and constants shared by the typed slot dispatcher modules.
`timescale 1ns / 1ps

package tsd_pkg;

    localparam logic [1:0] REQ_ASSIGN  = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_EVERY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_EXTRA = 2'd2;

    localparam logic [7:0]  LOAD_LIMIT_RST     = 8'd2;
    localparam logic [7:0]  COOLDOWN_EVERY_RST = 8'd3;
    localparam logic [15:0] COOLDOWN_EXTRA_RST = 16'd50;

    localparam int VISIBLE_MAX = 16;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  client_kind;
        logic [15:0] need_ticks;
        logic [3:0]  release_slot;
    } in_item_t;

    typedef struct packed {
        logic       granted;
        logic [3:0] slot_index;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  slot_type;
        logic [15:0] remaining;
        logic [7:0]  active;
        logic [7:0]  grant_phase;
        logic [15:0] cooldown;
    } slot_entry_t;

    typedef struct packed {
        logic load;
        logic clr_scan;
        logic rd_step;
        logic rd_pick;
        logic wr_update;
        logic post;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       ctype_zero;
        logic       rel_ok;
        logic       cnt_last;
        logic       found;
        logic       out_free;
    } status_t;

endpackage

@@ design/tsd_datapath.sv @@
// Datapath: slot table memory, scan trackers, slot update logic, output register.
`timescale 1ns / 1ps

module tsd_datapath #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tsd_pkg::cmd_t                  cmd,
    output tsd_pkg::status_t               stat,
    input  tsd_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tsd_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);

    localparam int AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int VIS = (SLOT_COUNT < tsd_pkg::VISIBLE_MAX) ? SLOT_COUNT
                                                             : tsd_pkg::VISIBLE_MAX;
    localparam logic [AW-1:0] LAST_ALL = AW'(SLOT_COUNT - 1);
    localparam logic [AW-1:0] LAST_VIS = AW'(VIS - 1);
    localparam logic [4:0]    VIS_W    = 5'(VIS);

    // Configuration
    logic [7:0]  load_limit_reg;
    logic [7:0]  cooldown_every_reg;
    logic [15:0] cooldown_extra_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_limit_reg     <= tsd_pkg::LOAD_LIMIT_RST;
            cooldown_every_reg <= tsd_pkg::COOLDOWN_EVERY_RST;
            cooldown_extra_reg <= tsd_pkg::COOLDOWN_EXTRA_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tsd_pkg::CFG_LOAD_LIMIT:     load_limit_reg     <= cfg_data[7:0];
                tsd_pkg::CFG_COOLDOWN_EVERY: cooldown_every_reg <= cfg_data[7:0];
                tsd_pkg::CFG_COOLDOWN_EXTRA: cooldown_extra_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Held item
    tsd_pkg::in_item_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    // Scan counter and read pipeline tags
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] da_reg;
    logic          dv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            dv_reg  <= 1'b0;
            da_reg  <= '0;
        end
        else
        begin
            dv_reg <= cmd.rd_step;
            da_reg <= cnt_reg;
            if (cmd.clr_scan)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.rd_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Slot table with per-entry valid bits standing in for the zero reset
    tsd_pkg::slot_entry_t mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;
    tsd_pkg::slot_entry_t  rd_reg;
    logic                  rvld_reg;
    tsd_pkg::slot_entry_t  entry;

    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;
    tsd_pkg::slot_entry_t wr_data;
    logic                 tick_wr;

    // Scan trackers
    logic          best_found_reg;
    logic [AW-1:0] best_idx_reg;
    logic [15:0]   best_time_reg;
    logic          free_found_reg;
    logic [AW-1:0] free_idx_reg;

    logic [AW-1:0] target_addr;
    logic [AW+3:0] rel_wide;
    logic [AW+3:0] tgt_wide;
    logic          is_assign;
    logic          best_hit;
    logic          free_hit;

    assign is_assign = (item_reg.req_type == tsd_pkg::REQ_ASSIGN);
    assign rel_wide  = {{AW{1'b0}}, item_reg.release_slot};
    assign target_addr = !is_assign ? rel_wide[AW-1:0]
                       : (best_found_reg ? best_idx_reg : free_idx_reg);
    assign tgt_wide  = {4'b0000, target_addr};

    assign entry   = rvld_reg ? rd_reg : '0;
    assign rd_addr = cmd.rd_pick ? target_addr : cnt_reg;
    assign tick_wr = dv_reg && (item_reg.req_type == tsd_pkg::REQ_TICK);
    assign wr_en   = cmd.wr_update || tick_wr;
    assign wr_addr = tick_wr ? da_reg : target_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_step || cmd.rd_pick)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_step || cmd.rd_pick)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Compare each scanned entry as it arrives
    assign best_hit = dv_reg && is_assign && (entry.cooldown == 16'd0)
                   && (entry.slot_type == item_reg.client_kind)
                   && (entry.active < load_limit_reg)
                   && (entry.remaining > best_time_reg);
    assign free_hit = dv_reg && is_assign && !free_found_reg
                   && (entry.slot_type == 8'd0) && (entry.cooldown == 16'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_time_reg  <= '0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.clr_scan)
        begin
            best_found_reg <= 1'b0;
            best_time_reg  <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (best_hit)
            begin
                best_found_reg <= 1'b1;
                best_time_reg  <= entry.remaining;
            end
            if (free_hit)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (best_hit)
        begin
            best_idx_reg <= da_reg;
        end
        if (free_hit)
        begin
            free_idx_reg <= da_reg;
        end
    end

    // Slot update: grant, release or tick
    logic [15:0] new_rem;
    logic [8:0]  phase_inc;
    logic [16:0] cd_sum;
    logic [7:0]  rel_active;

    assign new_rem   = (item_reg.need_ticks > entry.remaining) ? item_reg.need_ticks
                                                               : entry.remaining;
    assign phase_inc = {1'b0, entry.grant_phase} + 9'd1;
    assign cd_sum    = {1'b0, new_rem} + {1'b0, cooldown_extra_reg};
    assign rel_active = (entry.active != 8'd0) ? entry.active - 8'd1 : 8'd0;

    always_comb
    begin
        wr_data = entry;
        if (tick_wr)
        begin
            if (entry.remaining != 16'd0)
            begin
                wr_data.remaining = entry.remaining - 16'd1;
            end
            if (entry.cooldown != 16'd0)
            begin
                wr_data.cooldown = entry.cooldown - 16'd1;
            end
        end
        else if (is_assign)
        begin
            wr_data.slot_type = item_reg.client_kind;
            wr_data.remaining = new_rem;
            if (entry.active != 8'hFF)
            begin
                wr_data.active = entry.active + 8'd1;
            end
            if (cooldown_every_reg == 8'd0)
            begin
                if (entry.grant_phase != 8'hFF)
                begin
                    wr_data.grant_phase = phase_inc[7:0];
                end
            end
            else if (phase_inc >= {1'b0, cooldown_every_reg})
            begin
                wr_data.grant_phase = 8'd0;
                wr_data.cooldown    = cd_sum[16] ? 16'hFFFF : cd_sum[15:0];
            end
            else
            begin
                wr_data.grant_phase = phase_inc[7:0];
            end
        end
        else
        begin
            wr_data.active = rel_active;
            if (rel_active == 8'd0)
            begin
                wr_data.slot_type = 8'd0;
            end
        end
    end

    // Result and output register
    logic                granted_reg;
    logic [3:0]          idx_reg;
    logic                out_valid_reg;
    tsd_pkg::out_item_t  out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            granted_reg <= 1'b0;
            idx_reg     <= 4'd0;
        end
        else if (cmd.wr_update && is_assign)
        begin
            granted_reg <= 1'b1;
            idx_reg     <= tgt_wide[3:0];
        end
        if (cmd.post)
        begin
            out_data_reg.granted    <= granted_reg;
            out_data_reg.slot_index <= idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status back to the controller
    assign stat.req        = item_reg.req_type;
    assign stat.ctype_zero = (item_reg.client_kind == 8'd0);
    assign stat.rel_ok     = ({1'b0, item_reg.release_slot} < VIS_W);
    assign stat.cnt_last   = (cnt_reg == (is_assign ? LAST_VIS : LAST_ALL));
    assign stat.found      = best_found_reg || free_found_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

endmodule

@@ design/tsd_controller.sv @@
// Controller: sequences decode, slot scan, slot update, tick sweep and result posting.
`timescale 1ns / 1ps

module tsd_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tsd_pkg::status_t  stat,
    output tsd_pkg::cmd_t     cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_SCAN     = 4'd2;
    localparam logic [3:0] ST_SCAN_END = 4'd3;
    localparam logic [3:0] ST_CHOOSE   = 4'd4;
    localparam logic [3:0] ST_UPD      = 4'd5;
    localparam logic [3:0] ST_TICK     = 4'd6;
    localparam logic [3:0] ST_TICK_END = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.req == tsd_pkg::REQ_ASSIGN && !stat.ctype_zero)
                begin
                    cmd.clr_scan = 1'b1;
                    state_next   = ST_SCAN;
                end
                else if (stat.req == tsd_pkg::REQ_RELEASE && stat.rel_ok)
                begin
                    cmd.rd_pick = 1'b1;
                    state_next  = ST_UPD;
                end
                else if (stat.req == tsd_pkg::REQ_TICK)
                begin
                    cmd.clr_scan = 1'b1;
                    state_next   = ST_TICK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_step = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_CHOOSE;
            end
            ST_CHOOSE:
            begin
                if (stat.found)
                begin
                    cmd.rd_pick = 1'b1;
                    state_next  = ST_UPD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UPD:
            begin
                cmd.wr_update = 1'b1;
                state_next    = ST_DONE;
            end
            ST_TICK:
            begin
                cmd.rd_step = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = ST_TICK_END;
                end
            end
            ST_TICK_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/typed_slot_dispatcher.sv @@
// Top level of the typed slot dispatcher.
`timescale 1ns / 1ps

// Typed slot dispatcher. Takes one item at a time (assign, release or tick)
// and returns exactly one result item {granted, slot_index} per input item.
// An assign scans the visible slots (the first min(SLOT_COUNT,16)) one per
// cycle through the single read port of the slot table, keeping the best
// slot of the same type and the first free slot, then reads and rewrites the
// chosen slot; when no slot is found it skips the read and rewrite. A tick
// sweeps all SLOT_COUNT slots, reading one slot while writing back the
// previous one. A release reads and writes one slot unless its slot lies
// outside the visible range; other request codes and client type zero touch
// no slot. A stalled result register holds the next result back. in_stall
// is high from accept until the result has been moved into the output
// register; a result waiting there does not stop the next item being taken.
// The table needs no clearing pass after reset: per-slot valid bits make
// unwritten slots read as zero. Configuration writes are always ready.

module typed_slot_dispatcher #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tsd_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tsd_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data
);

    tsd_pkg::cmd_t    cmd;
    tsd_pkg::status_t stat;

    // Configuration never waits
    assign cfg_ready = 1'b1;

    tsd_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsd_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ design/tsd_checker.sv @@
// Port-level checker for the typed slot dispatcher, with its bind.
`timescale 1ns / 1ps
`include "typed_slot_dispatcher_assert.svh"

module tsd_checker #(
    parameter int SLOT_COUNT = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input tsd_pkg::out_item_t  out_data
);

    logic res_refused;
    logic res_granted;
    logic res_in_range;

    assign res_refused  = out_valid && !out_data.granted;
    assign res_granted  = out_valid && out_data.granted;
    assign res_in_range = (int'(out_data.slot_index) < SLOT_COUNT);

    // A refused assign, release or tick reports slot zero
    `TSD_ASSERT_NOW(a_idle_index, clk, rst_n, res_refused, out_data.slot_index == 4'd0)

    // A granted slot lies inside the table
    `TSD_ASSERT_NOW(a_grant_range, clk, rst_n, res_granted, res_in_range)

    // One item at a time: an accept closes the input for the next cycle
    `TSD_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)

    // A stalled result holds
    `TSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind typed_slot_dispatcher tsd_checker #(.SLOT_COUNT(SLOT_COUNT)) u_tsd_checker (.*);

@@ bench/typed_slot_dispatcher_tb.sv @@
// Self-checking testbench for the typed slot dispatcher: directed cases, phase saturation, random config sweep.
`timescale 1ns / 1ps

module typed_slot_dispatcher_tb;

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles allowed before giving up
    localparam int DRAIN_CYCLES   = 40;     // idle time spent watching for stray results
    localparam int SHOWN_ERRORS   = 10;

    // Request code the block must ignore, and the register index it must ignore.
    localparam logic [1:0]                    REQ_OTHER = 2'd3;
    localparam logic [tsd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_mode_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    tsd_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    tsd_pkg::out_item_t            out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tsd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                   cfg_data;

    typed_slot_dispatcher #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Dispatcher shadow: slot table and registers as the block should
    // hold them after every accepted item and every register write.
    // ------------------------------------------------------------------
    logic [7:0]  slot_kind  [SLOTS];   // client type tag, zero when free
    logic [15:0] slot_left  [SLOTS];   // remaining ticks
    logic [7:0]  slot_users [SLOTS];   // active clients
    logic [7:0]  slot_phase [SLOTS];   // grants since the last cooldown start
    logic [15:0] slot_cool  [SLOTS];   // cooldown ticks, nonzero blocks the slot

    logic [7:0]  lim_users;
    logic [7:0]  cool_every;
    logic [15:0] cool_extra;

    // Grant decisions still owed by the block, oldest first.
    tsd_pkg::out_item_t pending_grants[$];

    int burst_left     = 0;
    int count_by_req[4] = '{0, 0, 0, 0};
    int cfg_writes     = 0;
    int results_seen   = 0;
    int grants_seen    = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    // Book one grant on slot s: count the client, keep the longer need,
    // and start a cooldown on every cool_every-th grant.
    function automatic void book_grant(int s, logic [15:0] need);
        logic [16:0] cool_len;
        if (slot_users[s] != 8'hFF)
            slot_users[s] = slot_users[s] + 8'd1;
        if (need > slot_left[s])
            slot_left[s] = need;
        if (cool_every == 8'd0)
        begin
            // no cooldown at all; phase only counts up and sticks at the top
            if (slot_phase[s] != 8'hFF)
                slot_phase[s] = slot_phase[s] + 8'd1;
        end
        else if ({1'b0, slot_phase[s]} + 9'd1 >= {1'b0, cool_every})
        begin
            slot_phase[s] = 8'd0;
            cool_len      = {1'b0, slot_left[s]} + {1'b0, cool_extra};
            slot_cool[s]  = cool_len[16] ? 16'hFFFF : cool_len[15:0];
        end
        else
        begin
            slot_phase[s] = slot_phase[s] + 8'd1;
        end
    endfunction

    // Apply one item to the shadow table and return the grant it earns.
    function automatic tsd_pkg::out_item_t dispatch_predict(tsd_pkg::in_item_t it);
        tsd_pkg::out_item_t res;
        int                 pick;
        logic [15:0]        best_left;
        res       = '0;
        pick      = -1;
        best_left = '0;
        case (it.req_type)
            tsd_pkg::REQ_ASSIGN:
            begin
                if (it.client_kind != 8'd0)
                begin
                    // reuse: same type, not cooling, under the limit, longest time left
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (slot_cool[i] == 16'd0 && slot_kind[i] == it.client_kind &&
                            slot_users[i] < lim_users && slot_left[i] > best_left)
                        begin
                            best_left = slot_left[i];
                            pick      = i;
                        end
                    end
                    // otherwise claim the lowest free slot that is not cooling
                    if (pick < 0)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (pick < 0 && slot_kind[i] == 8'd0 && slot_cool[i] == 16'd0)
                            begin
                                slot_kind[i] = it.client_kind;
                                pick         = i;
                            end
                        end
                    end
                    if (pick >= 0)
                    begin
                        book_grant(pick, it.need_ticks);
                        res.granted    = 1'b1;
                        res.slot_index = 4'(pick);
                    end
                end
            end
            tsd_pkg::REQ_RELEASE:
            begin
                if (int'(it.release_slot) < SLOTS)
                begin
                    if (slot_users[it.release_slot] != 8'd0)
                        slot_users[it.release_slot] = slot_users[it.release_slot] - 8'd1;
                    if (slot_users[it.release_slot] == 8'd0)
                        slot_kind[it.release_slot] = 8'd0;
                end
            end
            tsd_pkg::REQ_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_left[i] != 16'd0)
                        slot_left[i] = slot_left[i] - 16'd1;
                    if (slot_cool[i] != 16'd0)
                        slot_cool[i] = slot_cool[i] - 16'd1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic tsd_pkg::in_item_t make_item(logic [1:0] req, logic [7:0] ctype,
                                                    logic [15:0] need, logic [3:0] rel);
        tsd_pkg::in_item_t it;
        it.req_type     = req;
        it.client_kind  = ctype;
        it.need_ticks   = need;
        it.release_slot = rel;
        return it;
    endfunction

    // Random request. Assigns favor a few client types and short needs so that
    // slots get reused, fill up and cool down; releases mostly hit busy slots.
    // Fields a request does not use carry random noise.
    function automatic tsd_pkg::in_item_t random_request(int wide_pct);
        tsd_pkg::in_item_t it;
        int                roll;
        int                busy[$];
        it.req_type     = REQ_OTHER;
        it.client_kind  = 8'($urandom_range(0, 255));
        it.need_ticks   = 16'($urandom_range(0, 65535));
        it.release_slot = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            it.req_type = tsd_pkg::REQ_ASSIGN;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                it.client_kind = 8'd0;
            else if (roll < 75)
                it.client_kind = 8'($urandom_range(1, 3));
            else
                it.client_kind = 8'($urandom_range(1, 255));
            roll = $urandom_range(0, 99);
            if (roll >= wide_pct)
                it.need_ticks = (roll < 70) ? 16'($urandom_range(0, 12))
                                            : 16'($urandom_range(0, 60));
        end
        else if (roll < 76)
        begin
            it.req_type = tsd_pkg::REQ_RELEASE;
            foreach (slot_users[i])
                if (slot_users[i] != 8'd0)
                    busy.push_back(i);
            if (busy.size() != 0 && $urandom_range(0, 99) < 75)
                it.release_slot = 4'(busy[$urandom_range(0, busy.size() - 1)]);
        end
        else if (roll < 96)
        begin
            it.req_type = tsd_pkg::REQ_TICK;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Entered and left at a falling edge. Hold the item until
    // the block takes it, predict its grant, then advance the burst pattern:
    // at the end of a burst drop valid for a random gap.
    // ------------------------------------------------------------------
    task automatic send_item(input tsd_pkg::in_item_t it);
        int gap;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        pending_grants.push_back(dispatch_predict(it));
        count_by_req[it.req_type]++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Drop valid and hold until every owed grant has come back. Each item
    // returns exactly one result, so an empty queue means the block is idle.
    task automatic wait_idle;
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(negedge clk);
    endtask

    // Write all registers, plus the unused index, while the block is idle.
    // The eight-bit registers get random upper bits that must be dropped.
    task automatic apply_settings(logic [7:0] lim_v, logic [7:0] every_v, logic [15:0] extra_v);
        logic [tsd_pkg::CFG_IDX_W-1:0] reg_idx [4];
        logic [15:0]                   reg_val [4];
        reg_idx = '{tsd_pkg::CFG_LOAD_LIMIT, tsd_pkg::CFG_COOLDOWN_EVERY,
                    tsd_pkg::CFG_COOLDOWN_EXTRA, CFG_SPARE};
        reg_val = '{{8'($urandom_range(0, 255)), lim_v},
                    {8'($urandom_range(0, 255)), every_v},
                    extra_v,
                    16'($urandom_range(0, 65535))};
        wait_idle();
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx[k];
            cfg_data  <= reg_val[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (reg_idx[k])
                tsd_pkg::CFG_LOAD_LIMIT:     lim_users  = reg_val[k][7:0];
                tsd_pkg::CFG_COOLDOWN_EVERY: cool_every = reg_val[k][7:0];
                tsd_pkg::CFG_COOLDOWN_EXTRA: cool_extra = reg_val[k];
                default: ;
            endcase
            cfg_writes++;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked sequence at reset settings (limit 2, cooldown every 3,
    // extra 50). Slot numbers in releases follow the fill order below.
    task automatic test_directed_cases;
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd5, 16'd10, 4'd0));     // claim free slot 0
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd5, 16'd4, 4'd0));      // reuse slot 0
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd5, 16'd7, 4'd0));      // slot 0 full, claim 1
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd5, 16'd20, 4'd0));     // reuse slot 1
        send_item(make_item(tsd_pkg::REQ_RELEASE, 8'd0, 16'd0, 4'd0));     // slot 0 under limit
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd5, 16'd1, 4'd0));      // third grant: cooldown
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd9, 16'd0, 4'd0));      // claim slot 2, no time
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd9, 16'd3, 4'd0));      // zero time not reused
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd0, 16'hFFFF, 4'hF));   // client type zero
        send_item(make_item(REQ_OTHER, 8'hFF, 16'hFFFF, 4'hF));            // unused request code
        send_item(make_item(tsd_pkg::REQ_TICK, 8'd0, 16'd0, 4'd0));
        send_item(make_item(tsd_pkg::REQ_RELEASE, 8'hFF, 16'hFFFF, 4'hF)); // idle slot release
        send_item(make_item(tsd_pkg::REQ_RELEASE, 8'd0, 16'd0, 4'd2));     // last client leaves
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'hFF, 16'hFFFF, 4'd0));  // largest type and time
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd7, 16'd5, 4'd0));
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd7, 16'd5, 4'd0));
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd7, 16'd5, 4'd0));      // second slot, same time
        send_item(make_item(tsd_pkg::REQ_RELEASE, 8'd0, 16'd0, 4'd4));
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd7, 16'd1, 4'd0));      // tie to the lower slot
        send_item(make_item(tsd_pkg::REQ_TICK, 8'd0, 16'd0, 4'd0));
        send_item(make_item(tsd_pkg::REQ_TICK, 8'd0, 16'd0, 4'd0));
        send_item(make_item(tsd_pkg::REQ_ASSIGN, 8'd1, 16'h8000, 4'd0));
    endtask

    // With cooldowns off, drive one slot's grant phase to the top and past
    // it, then lower the cooldown period below the phase: the next grant
    // must start a cooldown and clear the phase.
    task automatic test_grant_phase_saturation;
        tsd_pkg::in_item_t grab;
        tsd_pkg::in_item_t drop;
        int                hot;
        grab = make_item(tsd_pkg::REQ_ASSIGN, 8'd200, 16'd3, 4'd0);
        hot  = -1;
        apply_settings(8'd255, 8'd0, 16'd0);
        repeat (255) send_item(grab);
        foreach (slot_kind[i])
            if (hot < 0 && slot_kind[i] == 8'd200)
                hot = i;
        if (hot >= 0)
        begin
            drop = make_item(tsd_pkg::REQ_RELEASE, 8'd0, 16'd0, 4'(hot));
            send_item(drop);
            send_item(grab);                       // phase already at the top, stays
            apply_settings(8'd255, 8'd2, 16'd0);
            send_item(drop);
            send_item(grab);                       // phase above the period: cooldown
            while (slot_users[hot] != 8'd0)
                send_item(drop);
            for (int n = 0; n < 20 && slot_cool[hot] != 16'd0; n++)
                send_item(make_item(tsd_pkg::REQ_TICK, 8'd0, 16'd0, 4'd0));
        end
    endtask

    // One setting, then random traffic until enough items that do something
    // have gone in; ignored codes and type-zero assigns come along as noise.
    task automatic run_random_phase(logic [7:0] lim_v, logic [7:0] every_v,
                                    logic [15:0] extra_v, int target, int wide_pct);
        tsd_pkg::in_item_t it;
        int                useful;
        useful = 0;
        apply_settings(lim_v, every_v, extra_v);
        while (useful < target)
        begin
            it = random_request(wide_pct);
            send_item(it);
            if (it.req_type != REQ_OTHER &&
                !(it.req_type == tsd_pkg::REQ_ASSIGN && it.client_kind == 8'd0))
                useful++;
        end
    endtask

    // Sweep settings through their extremes. The saturating-extra phase runs
    // last since its cooldowns lock slots for the rest of the run.
    task automatic test_config_sweep;
        run_random_phase(8'd1, 8'd1, 16'd0, 140, 0);
        run_random_phase(8'd255, 8'd255, 16'($urandom_range(0, 40)), 140, 0);
        run_random_phase(8'($urandom_range(1, 4)), 8'd0, 16'($urandom_range(0, 40)), 140, 0);
        run_random_phase(8'd0, 8'($urandom_range(1, 6)), 16'($urandom_range(0, 40)), 70, 0);
        run_random_phase(8'($urandom_range(2, 8)), 8'($urandom_range(1, 6)),
                         16'($urandom_range(0, 40)), 140, 0);
        run_random_phase(8'($urandom_range(2, 8)), 8'($urandom_range(2, 5)),
                         16'hFFFF, 140, 6);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall on a pattern of its own, switching between no
    // stalls, light and heavy random stalls, and long alternating runs.
    // ------------------------------------------------------------------
    initial
    begin
        stall_mode_t mode;
        int          span;
        int          run;
        out_stall = 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            run  = 0;
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                    STALL_RUNS:
                    begin
                        if (run == 0)
                        begin
                            run = $urandom_range(1, 24);
                            out_stall <= ~out_stall;
                        end
                        run--;
                    end
                    default:     out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    function automatic void log_error(string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("ERROR: %s", msg);
    endfunction

    // Compare each accepted result with the oldest owed grant.
    always @(posedge clk)
    begin
        tsd_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_grants.size() == 0)
            begin
                log_error($sformatf("result %0d arrived with nothing owed: granted %0b slot %0d",
                                    results_seen, out_data.granted, out_data.slot_index));
            end
            else
            begin
                want = pending_grants.pop_front();
                if (out_data.granted !== want.granted)
                    log_error($sformatf("result %0d granted: expected %0b, got %0b",
                                        results_seen, want.granted, out_data.granted));
                if (out_data.slot_index !== want.slot_index)
                    log_error($sformatf("result %0d slot_index: expected %0d, got %0d",
                                        results_seen, want.slot_index, out_data.slot_index));
                if (out_data.granted === 1'b1)
                    grants_seen++;
            end
        end
    end

    // Watchdog: end the run when no channel has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d results owed",
                         quiet_cycles, pending_grants.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        lim_users  = tsd_pkg::LOAD_LIMIT_RST;
        cool_every = tsd_pkg::COOLDOWN_EVERY_RST;
        cool_extra = tsd_pkg::COOLDOWN_EXTRA_RST;
        foreach (slot_kind[i])
        begin
            slot_kind[i]  = '0;
            slot_left[i]  = '0;
            slot_users[i] = '0;
            slot_phase[i] = '0;
            slot_cool[i]  = '0;
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_grant_phase_saturation();
        test_config_sweep();

        // let the last results drain, then watch for strays
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d assigns, %0d releases, %0d ticks, %0d unused codes; %0d register writes.",
                 count_by_req[tsd_pkg::REQ_ASSIGN], count_by_req[tsd_pkg::REQ_RELEASE],
                 count_by_req[tsd_pkg::REQ_TICK], count_by_req[REQ_OTHER], cfg_writes);
        $display("Checked %0d results, %0d grants among them; %0d errors.",
                 results_seen, grants_seen, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tsd_pkg.sv
design/tsd_datapath.sv
design/tsd_controller.sv
design/typed_slot_dispatcher.sv
design/tsd_checker.sv
bench/typed_slot_dispatcher_tb.sv
